// File: hw/rtl/ejsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ejsa_pkg
// shared types and constants of the element-by-element jacobi accumulator
// ----------------------------------------------------------------------------
package ejsa_pkg;

	localparam int MAX_EQUATIONS = 4096;
	localparam int ADDR_BITS     = $clog2(MAX_EQUATIONS);
	localparam int INDEX_BITS    = 13;
	localparam int VALUE_BITS    = 32;
	localparam int FRAC_BITS     = 16;
	localparam int PROD_BITS     = 2 * VALUE_BITS;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_APPLY = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_ROUND,
		ST_ACC,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;    // take the request from the ports
		logic sweep;      // clear one written mark
		logic clear_ovf;  // drop the sticky overflow flag
		logic load_wr;    // write the input entry
		logic mul;        // form the raw product
		logic round;      // round and saturate the product
		logic acc;        // add into the result entry and write back
		logic emit;       // present a read result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic live;
		logic sweep_last;
	} status_t;

endpackage

// File: hw/rtl/ejsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ejsa_ctrl
// request sequencer: decodes each request and steps the datapath through it
// ----------------------------------------------------------------------------
module ejsa_ctrl import ejsa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output logic    busy,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (status.op)
					OP_CLEAR: begin
						cmd.clear_ovf = 1'b1;
						state_d       = ST_SWEEP;
					end
					OP_LOAD: begin
						cmd.load_wr = status.live;
						state_d     = ST_IDLE;
					end
					OP_APPLY: begin
						state_d = status.live ? ST_MUL : ST_IDLE;
					end
					OP_READ: begin
						state_d = ST_RESULT;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_IDLE;
			end
			ST_RESULT: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/ejsa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ejsa_datapath
// vector stores, fixed-point multiply, rounding, saturating accumulate
// ----------------------------------------------------------------------------
module ejsa_datapath import ejsa_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output status_t                       status,
	input  logic                          cfg_wen,
	input  logic [INDEX_BITS-1:0]         cfg_wdata,
	input  logic [1:0]                    operation,
	input  logic [INDEX_BITS-1:0]         dof_index,
	input  logic signed [VALUE_BITS-1:0]  operand_value,
	output logic signed [VALUE_BITS-1:0]  result_value,
	output logic [INDEX_BITS-1:0]         result_index,
	output logic                          overflow_seen,
	output logic                          result_strobe
);

	localparam logic [INDEX_BITS-1:0] MAX_COUNT = INDEX_BITS'(MAX_EQUATIONS);
	localparam logic signed [PROD_BITS-1:0] HALF_LESS_ONE =
		PROD_BITS'((64'd1 << (FRAC_BITS - 1)) - 64'd1);
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// memories: input vector, result vector with its written mark on top
	logic [VALUE_BITS-1:0] in_mem  [MAX_EQUATIONS];
	logic [VALUE_BITS:0]   res_mem [MAX_EQUATIONS];

	logic [INDEX_BITS-1:0]        count_q;
	op_t                          op_q;
	logic [INDEX_BITS-1:0]        idx_q;
	logic signed [VALUE_BITS-1:0] operand_q;
	logic                         live_q;
	logic [ADDR_BITS-1:0]         sweep_cnt_q;
	logic                         ovf_q;
	logic signed [VALUE_BITS-1:0] in_rd_q;
	logic [VALUE_BITS:0]          res_rd_q;
	logic signed [PROD_BITS-1:0]  product_s1;
	logic signed [VALUE_BITS-1:0] prod_s2;
	logic signed [VALUE_BITS-1:0] result_value_q;
	logic [INDEX_BITS-1:0]        result_index_q;
	logic                         overflow_seen_q;
	logic                         result_strobe_q;

	logic [INDEX_BITS-1:0]        eff_count;
	logic [ADDR_BITS-1:0]         addr;
	logic signed [PROD_BITS-1:0]  rnd_sum;
	logic                         rnd_ovf;
	logic signed [VALUE_BITS-1:0] rnd_val;
	logic signed [VALUE_BITS-1:0] old_val;
	logic signed [VALUE_BITS:0]   acc_sum;
	logic                         acc_ovf;
	logic signed [VALUE_BITS-1:0] acc_val;

	assign eff_count = (count_q > MAX_COUNT) ? MAX_COUNT : count_q;
	assign addr      = idx_q[ADDR_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= MAX_COUNT;
		end else if (cfg_wen) begin
			count_q <= cfg_wdata;
		end
	end

	// captured request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= op_t'(operation);
			idx_q     <= dof_index;
			operand_q <= operand_value;
			live_q    <= dof_index < eff_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
		end else if (cmd.sweep) begin
			sweep_cnt_q <= sweep_cnt_q + 1'b1;
		end
	end

	assign status.op         = op_q;
	assign status.live       = live_q;
	assign status.sweep_last = &sweep_cnt_q;

	// memory ports
	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			in_mem[addr] <= operand_q;
		end
		in_rd_q <= in_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			res_mem[sweep_cnt_q] <= '0;
		end else if (cmd.acc) begin
			res_mem[addr] <= {1'b1, acc_val};
		end
		res_rd_q <= res_mem[addr];
	end

	// product rounded to nearest, ties away from zero
	assign rnd_sum = product_s1 + HALF_LESS_ONE + PROD_BITS'(!product_s1[PROD_BITS-1]);
	assign rnd_ovf = !((&rnd_sum[PROD_BITS-1:FRAC_BITS+VALUE_BITS-1])
		|| !(|rnd_sum[PROD_BITS-1:FRAC_BITS+VALUE_BITS-1]));
	assign rnd_val = rnd_ovf ? (rnd_sum[PROD_BITS-1] ? VAL_MIN : VAL_MAX)
		: rnd_sum[FRAC_BITS+VALUE_BITS-1:FRAC_BITS];

	// unwritten entries count as zero
	assign old_val = res_rd_q[VALUE_BITS] ? res_rd_q[VALUE_BITS-1:0] : '0;
	assign acc_sum = {old_val[VALUE_BITS-1], old_val} + {prod_s2[VALUE_BITS-1], prod_s2};
	assign acc_ovf = acc_sum[VALUE_BITS] != acc_sum[VALUE_BITS-1];
	assign acc_val = acc_ovf ? (acc_sum[VALUE_BITS] ? VAL_MIN : VAL_MAX)
		: acc_sum[VALUE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			product_s1 <= in_rd_q * operand_q;
		end
		if (cmd.round) begin
			prod_s2 <= rnd_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (cmd.clear_ovf) begin
			ovf_q <= 1'b0;
		end else if ((cmd.round && rnd_ovf) || (cmd.acc && acc_ovf)) begin
			ovf_q <= 1'b1;
		end
	end

	// read result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_value_q  <= (live_q && res_rd_q[VALUE_BITS]) ?
				res_rd_q[VALUE_BITS-1:0] : '0;
			result_index_q  <= idx_q;
			overflow_seen_q <= ovf_q;
		end
	end

	assign result_value  = result_value_q;
	assign result_index  = result_index_q;
	assign overflow_seen = overflow_seen_q;
	assign result_strobe = result_strobe_q;

endmodule

// File: hw/rtl/ebe_jacobi_scatter_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebe_jacobi_scatter_accumulate
// element-by-element jacobi preconditioner: scatter-accumulate of d^-1 * p
// ----------------------------------------------------------------------------
// a request is taken at a clock edge where start is high and busy is low.
// a read result appears on result_value / result_index / overflow_seen for
// exactly one cycle, marked by result_strobe, in the cycle after the
// sequencer's result state; the receiver cannot stall it, so it must
// sample it then. busy is low only when the sequencer is idle. each
// request passes through a decode state; an apply then steps through
// memory read, 32x32 multiply, round and saturate, add and write back,
// one step each, and a clear runs the written-mark sweep over all 4096
// result entries, one entry per cycle. after reset the same sweep runs
// before the first request is taken; equation_count may be written during
// it. equation_count is written with cfg_wen / cfg_wdata and must only be
// changed while the block is idle. values are signed q16.16; products round
// to nearest with ties away from zero, products and sums saturate, and any
// saturation sets overflow_seen until the next clear.
// ----------------------------------------------------------------------------
module ebe_jacobi_scatter_accumulate import ejsa_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: equation_count
	input  logic                          cfg_wen,
	input  logic [INDEX_BITS-1:0]         cfg_wdata,
	// request side
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic [INDEX_BITS-1:0]         dof_index,
	input  logic signed [VALUE_BITS-1:0]  operand_value,
	// result side
	output logic                          result_strobe,
	output logic signed [VALUE_BITS-1:0]  result_value,
	output logic [INDEX_BITS-1:0]         result_index,
	output logic                          overflow_seen
);

	cmd_t    cmd;
	status_t status;

	// sequencer: one state per processing step
	ejsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// vector memories and arithmetic
	ejsa_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.operation     (operation),
		.dof_index     (dof_index),
		.operand_value (operand_value),
		.result_value  (result_value),
		.result_index  (result_index),
		.overflow_seen (overflow_seen),
		.result_strobe (result_strobe)
	);

endmodule

// File: verif/tb_ebe_jacobi_scatter_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ebe_jacobi_scatter_accumulate
// self-checking bench for the element-by-element jacobi scatter-accumulator
// ----------------------------------------------------------------------------
// a short table of directed requests walks the extremes: reads after reset,
// the dummy slot, out-of-range indices, product and sum saturation, rounding
// ties and clears. random load / apply / read sequences follow, over several
// equation_count settings with random sender gaps. every read result is
// compared field by field against a typed expectation or a local q16.16 model.
// ----------------------------------------------------------------------------
module tb_ebe_jacobi_scatter_accumulate;
	import ejsa_pkg::*;

	localparam int     CLK_PERIOD     = 12;
	localparam longint TIMEOUT_CYCLES = 3_000_000;
	localparam int     PHASE_ITEMS    = 195;
	localparam int     N_DIRECTED     = 26;
	localparam int     N_PHASES       = 10;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [INDEX_BITS-1:0] index;
		logic                  ovf;
	} read_result_t;

	typedef struct {
		op_t                   op;
		logic [INDEX_BITS-1:0] idx;
		logic [VALUE_BITS-1:0] operand;
		bit                    typed;
		read_result_t          want;
	} stim_row_t;

	logic                         clk           = 1'b0;
	logic                         arst_n        = 1'b0;
	logic                         cfg_wen       = 1'b0;
	logic [INDEX_BITS-1:0]        cfg_wdata     = '0;
	logic                         start         = 1'b0;
	logic                         busy;
	logic [1:0]                   operation     = OP_CLEAR;
	logic [INDEX_BITS-1:0]        dof_index     = '0;
	logic signed [VALUE_BITS-1:0] operand_value = '0;
	logic                         result_strobe;
	logic signed [VALUE_BITS-1:0] result_value;
	logic [INDEX_BITS-1:0]        result_index;
	logic                         overflow_seen;

	ebe_jacobi_scatter_accumulate dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.dof_index     (dof_index),
		.operand_value (operand_value),
		.result_strobe (result_strobe),
		.result_value  (result_value),
		.result_index  (result_index),
		.overflow_seen (overflow_seen)
	);

	// free-running clock, 12 ns period
	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// shadow copy of the block state
	logic [VALUE_BITS-1:0] shadow_input  [MAX_EQUATIONS];
	logic [VALUE_BITS-1:0] shadow_result [MAX_EQUATIONS];
	bit                    shadow_written[MAX_EQUATIONS];
	// input entries loaded since reset; applies to live entries only go to these
	bit                    input_loaded  [MAX_EQUATIONS];
	bit                    shadow_ovf    = 1'b0;
	int unsigned           shadow_count  = MAX_EQUATIONS;

	read_result_t pending_reads[$];
	int unsigned  error_count = 0;
	int unsigned  items_sent  = 0;
	int unsigned  gap_percent = 9;

	stim_row_t directed_rows[N_DIRECTED];

	// counts above the store size behave like the store size
	function automatic int unsigned active_equations();
		return (shadow_count > MAX_EQUATIONS) ? MAX_EQUATIONS : shadow_count;
	endfunction

	// q16.16 product, round half away from zero, saturate
	function automatic logic [VALUE_BITS-1:0] q16_mul(input logic [VALUE_BITS-1:0] a,
			input logic [VALUE_BITS-1:0] b, output bit sat);
		longint      prod;
		logic [63:0] mag;
		logic [63:0] q;
		logic [63:0] lim;
		bit          neg;
		prod = longint'($signed(a)) * longint'($signed(b));
		neg  = a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
		mag  = (prod < 0) ? -prod : prod;
		q    = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		lim  = 64'h7FFF_FFFF + neg;
		sat  = (q > lim);
		if (sat)
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return neg ? -q[VALUE_BITS-1:0] : q[VALUE_BITS-1:0];
	endfunction

	// saturating accumulate
	function automatic logic [VALUE_BITS-1:0] q16_add(input logic [VALUE_BITS-1:0] a,
			input logic [VALUE_BITS-1:0] b, output bit sat);
		longint s;
		s   = longint'($signed(a)) + longint'($signed(b));
		sat = 1'b1;
		if (s > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (s < -64'sd2147483648)
			return 32'h8000_0000;
		sat = 1'b0;
		return s[VALUE_BITS-1:0];
	endfunction

	// advance the shadow state by one request; returns 1 when a read result follows
	function automatic bit jacobi_step(input op_t op, input logic [INDEX_BITS-1:0] idx,
			input logic [VALUE_BITS-1:0] operand, output read_result_t res);
		logic [ADDR_BITS-1:0]  a;
		logic [VALUE_BITS-1:0] prod;
		logic [VALUE_BITS-1:0] old;
		bit                    sat_mul;
		bit                    sat_sum;
		bit                    live;
		a    = idx[ADDR_BITS-1:0];
		live = (idx < active_equations());
		res  = '0;
		case (op)
			OP_CLEAR: begin
				foreach (shadow_written[i])
					shadow_written[i] = 1'b0;
				shadow_ovf = 1'b0;
			end
			OP_LOAD: begin
				if (live) begin
					shadow_input[a] = operand;
					input_loaded[a] = 1'b1;
				end
			end
			OP_APPLY: begin
				if (live) begin
					prod              = q16_mul(shadow_input[a], operand, sat_mul);
					old               = shadow_written[a] ? shadow_result[a] : '0;
					shadow_result[a]  = q16_add(old, prod, sat_sum);
					shadow_written[a] = 1'b1;
					if (sat_mul || sat_sum)
						shadow_ovf = 1'b1;
				end
			end
			default: begin
				res.value = (live && shadow_written[a]) ? shadow_result[a] : '0;
				res.index = idx;
				res.ovf   = shadow_ovf;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	// present one request, hold it until taken, then log what it should return
	task automatic send_request(input op_t op, input logic [INDEX_BITS-1:0] idx,
			input logic [VALUE_BITS-1:0] operand, input bit typed = 1'b0,
			input read_result_t typed_res = '0);
		read_result_t res;
		while (gap_percent != 0 && $urandom_range(99) < gap_percent) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		operation     <= op;
		dof_index     <= idx;
		operand_value <= operand;
		do
			@(posedge clk);
		while (busy);
		if (jacobi_step(op, idx, operand, res))
			pending_reads.push_back(typed ? typed_res : res);
	endtask

	// random request: applies to never-loaded live entries turn into loads
	task automatic random_request(input op_t op, input logic [INDEX_BITS-1:0] idx,
			input logic [VALUE_BITS-1:0] operand, inout int unsigned counted);
		bit live;
		live = (idx < active_equations());
		if (op == OP_APPLY && live && !input_loaded[idx[ADDR_BITS-1:0]])
			op = OP_LOAD;
		gap_percent = (items_sent < 650) ? 9 : (items_sent < 1300) ? 57 : 0;
		send_request(op, idx, operand);
		// every accepted request counts, dropped ones included
		counted++;
		items_sent++;
	endtask

	// wait until no read is outstanding and the sequencer is back to idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending_reads.size() != 0)
			@(posedge clk);
		// loads and applies leave no result, allow the apply pipeline to empty
		repeat (8) @(posedge clk);
	endtask

	task automatic write_equation_count(input logic [INDEX_BITS-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen      <= 1'b0;
		shadow_count = value;
	endtask

	// mostly a small working window so entries accumulate several times
	function automatic logic [INDEX_BITS-1:0] pick_index();
		int unsigned n;
		int unsigned r;
		n = active_equations();
		r = $urandom_range(99);
		if (r < 5)
			return INDEX_BITS'(n);
		if (r < 10)
			return INDEX_BITS'($urandom_range(0, (1 << INDEX_BITS) - 1));
		if (n == 0)
			return '0;
		if (r < 15)
			return INDEX_BITS'(n - 1);
		if (r < 22)
			return INDEX_BITS'($urandom_range(0, n - 1));
		return INDEX_BITS'($urandom_range(0, ((n < 48) ? n : 48) - 1));
	endfunction

	function automatic logic [VALUE_BITS-1:0] pick_operand();
		logic [VALUE_BITS-1:0] v;
		int unsigned           r;
		r = $urandom_range(99);
		if (r < 40)
			v = $urandom_range(0, 32'h0004_0000);          // up to 4.0
		else if (r < 55)
			v = $urandom_range(0, 32'h0001_0000);          // fractions, rounding ties
		else if (r < 85)
			v = $urandom;
		else begin
			case ($urandom_range(0, 5))
				0:       v = 32'h7FFF_FFFF;
				1:       v = 32'h8000_0000;
				2:       v = 32'h0001_0000;
				3:       v = 32'h0000_8000;
				4:       v = 32'h0000_0001;
				default: v = 32'h0000_0000;
			endcase
		end
		if (r < 55 && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// result side: the receiver never stalls, every strobe is a result
	always @(posedge clk) begin
		read_result_t want;
		if (arst_n && result_strobe) begin
			if (pending_reads.size() == 0) begin
				$error("read result with nothing outstanding: index %0d", result_index);
				error_count++;
			end else begin
				want = pending_reads.pop_front();
				if (result_value !== want.value) begin
					$error("result_value mismatch: expected %0d, got %0d",
						$signed(want.value), result_value);
					error_count++;
				end
				if (result_index !== want.index) begin
					$error("result_index mismatch: expected %0d, got %0d",
						want.index, result_index);
					error_count++;
				end
				if (overflow_seen !== want.ovf) begin
					$error("overflow_seen mismatch: expected %0d, got %0d",
						want.ovf, overflow_seen);
					error_count++;
				end
			end
		end
	end

	initial begin
		logic [INDEX_BITS-1:0] phase_counts[N_PHASES];
		logic [INDEX_BITS-1:0] idx;
		int unsigned           counted;
		int unsigned           wait_cycles;

		// directed table: typed expectations only where obvious
		directed_rows = '{
			// reads straight after reset, dummy slot and beyond
			'{OP_READ,  13'd0,    32'h0000_0000, 1'b1, '{32'h0000_0000, 13'd0,    1'b0}},
			'{OP_READ,  13'd4096, 32'h0000_0000, 1'b1, '{32'h0000_0000, 13'd4096, 1'b0}},
			'{OP_READ,  13'd8191, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 13'd8191, 1'b0}},
			// 1.0 * 2.0
			'{OP_LOAD,  13'd0,    32'h0001_0000, 1'b0, '0},
			'{OP_APPLY, 13'd0,    32'h0002_0000, 1'b0, '0},
			'{OP_READ,  13'd0,    32'h0000_0000, 1'b1, '{32'h0002_0000, 13'd0,    1'b0}},
			// largest positive squared saturates the product
			'{OP_LOAD,  13'd4095, 32'h7FFF_FFFF, 1'b0, '0},
			'{OP_APPLY, 13'd4095, 32'h7FFF_FFFF, 1'b0, '0},
			'{OP_READ,  13'd4095, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 13'd4095, 1'b1}},
			// clear drops marks and overflow
			'{OP_CLEAR, 13'd8191, 32'hFFFF_FFFF, 1'b0, '0},
			'{OP_READ,  13'd4095, 32'h0000_0000, 1'b1, '{32'h0000_0000, 13'd4095, 1'b0}},
			// most negative squared, then pull back by a half
			'{OP_LOAD,  13'd1,    32'h8000_0000, 1'b0, '0},
			'{OP_APPLY, 13'd1,    32'h8000_0000, 1'b0, '0},
			'{OP_APPLY, 13'd1,    32'h0000_8000, 1'b0, '0},
			'{OP_READ,  13'd1,    32'h0000_0000, 1'b0, '0},
			// rounding ties away from zero, both signs
			'{OP_LOAD,  13'd2,    32'h0000_0001, 1'b0, '0},
			'{OP_APPLY, 13'd2,    32'h0000_8000, 1'b0, '0},
			'{OP_APPLY, 13'd2,    32'hFFFF_8000, 1'b0, '0},
			'{OP_READ,  13'd2,    32'h0000_0000, 1'b0, '0},
			// exact most negative product, negative sum saturation, then +max
			'{OP_LOAD,  13'd3,    32'h8000_0000, 1'b0, '0},
			'{OP_APPLY, 13'd3,    32'h0001_0000, 1'b0, '0},
			'{OP_APPLY, 13'd3,    32'h0001_0000, 1'b0, '0},
			'{OP_APPLY, 13'd3,    32'hFFFF_0000, 1'b0, '0},
			'{OP_READ,  13'd3,    32'h0000_0000, 1'b0, '0},
			// apply on the dummy slot is dropped
			'{OP_APPLY, 13'd4096, 32'h0001_0000, 1'b0, '0},
			'{OP_READ,  13'd4096, 32'h1234_5678, 1'b0, '0}
		};

		// equation_count settings per random phase, extremes included
		phase_counts = '{13'd4096, 13'd1, 13'd8191, 13'd37, 13'd0,
			13'd4095, 13'd4097, 13'd0, 13'd2, 13'd4096};
		phase_counts[7] = INDEX_BITS'($urandom_range(1, MAX_EQUATIONS));

		// reset once, then release on an edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// first request waits out the mark sweep through busy
		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].operand,
				directed_rows[i].typed, directed_rows[i].want);
		items_sent = N_DIRECTED;

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			write_equation_count(phase_counts[p]);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if ($urandom_range(99) < 5)
					random_request(OP_CLEAR, INDEX_BITS'($urandom_range(0, 8191)), $urandom,
						counted);
				if ($urandom_range(99) < 85) begin
					// well-formed request sequence: load (skipped at times for a loaded entry), one to four applies, read back
					idx = pick_index();
					if (!(idx < active_equations() && input_loaded[idx[ADDR_BITS-1:0]]
							&& $urandom_range(99) < 30))
						random_request(OP_LOAD, idx, pick_operand(), counted);
					repeat ($urandom_range(1, 4))
						random_request(OP_APPLY, idx, pick_operand(), counted);
					random_request(OP_READ, idx, $urandom, counted);
				end else begin
					// noise: any request anywhere
					random_request(op_t'($urandom_range(0, 3)), pick_index(), pick_operand(),
						counted);
				end
			end
		end

		// let outstanding reads come back, with a bound
		start <= 1'b0;
		for (wait_cycles = 0; wait_cycles < 20000 && (busy || pending_reads.size() != 0);
				wait_cycles++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (pending_reads.size() != 0) begin
			$error("%0d read results never arrived", pending_reads.size());
			error_count++;
		end

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
